// File: rtl/core/tprc_pkg.sv
// ----------------------------------------------------------------------------
// tprc_pkg
// Shared types and constants of the triple pair repeat checker.
// ----------------------------------------------------------------------------
package tprc_pkg;

  localparam int MAX_ELEMENTS = 21;
  localparam int MAX_LINES    = 16;

  localparam int ELEM_W   = 5;
  localparam int LINE_W   = 4;
  localparam int GROUP_W  = 3;
  localparam int STATUS_W = 2;

  localparam int TABLE_DEPTH = MAX_ELEMENTS * MAX_ELEMENTS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int EPOCH_W     = 8;
  localparam int RAM_W       = EPOCH_W + LINE_W;

  localparam logic [ELEM_W-1:0] NUM_ELEM_RESET = ELEM_W'(21);
  localparam logic [ELEM_W-1:0] NUM_ELEM_SMALL = ELEM_W'(15);
  localparam logic [ELEM_W-1:0] NUM_ELEM_LARGE = ELEM_W'(21);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_INVALID = 2'd2,
    ST_SKIPPED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_CMP,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PAIR_AB = 2'd0,
    PAIR_AC = 2'd1,
    PAIR_BC = 2'd2
  } pair_e;

endpackage

// File: rtl/core/tprc_ram.sv
// ----------------------------------------------------------------------------
// tprc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tprc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/triple_pair_repeat_checker.sv
// ----------------------------------------------------------------------------
// triple_pair_repeat_checker
// Checks triples of a matrix for repeated or invalid element pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one triple with its line,
//   group and matrix marks. Output channel (out_valid_o / out_stall_i) gives
//   one result per triple. cfg_valid_i / cfg_ready_o writes num_elements.
//   A triple is taken only while the sequencer is idle. Its three pairs go
//   one after another through a single range/compare unit and the pair
//   table RAM, in a read state (S_ADDR) and a compare/write state (S_CMP)
//   per pair, since the RAM is read and then written for each pair. The
//   next triple is taken in the cycle after the result loads into the
//   output register, once the sequencer is back in its idle state.
//   The table holds an epoch tag per pair; a first_of_matrix mark advances
//   the epoch. When the epoch wraps, and after reset, a clearing pass
//   writes all 441 table entries while no triple is taken.
//   A finished result sits in the output register; while out_stall_i is
//   high it holds, and the block still takes the next triple but waits to
//   deliver it until the register frees up.
// ----------------------------------------------------------------------------
module triple_pair_repeat_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tprc_pkg::ELEM_W-1:0]    cfg_num_elements_i,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tprc_pkg::ELEM_W-1:0]    elem_a_i,
  input  logic [tprc_pkg::ELEM_W-1:0]    elem_b_i,
  input  logic [tprc_pkg::ELEM_W-1:0]    elem_c_i,
  input  logic [tprc_pkg::LINE_W-1:0]    line_index_i,
  input  logic [tprc_pkg::GROUP_W-1:0]   group_index_i,
  input  logic                           first_of_matrix_i,
  input  logic                           last_of_matrix_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tprc_pkg::STATUS_W-1:0]  status_o,
  output logic [tprc_pkg::LINE_W-1:0]    fail_line_o,
  output logic [tprc_pkg::GROUP_W-1:0]   fail_group_o,
  output logic [tprc_pkg::LINE_W-1:0]    dup_line_o,
  output logic                           matrix_done_o,
  output logic                           matrix_ok_o
);

  tprc_pkg::state_e                   state_q, state_d;
  tprc_pkg::pair_e                    pair_q, pair_d;
  tprc_pkg::status_e                  status_q, status_d;
  logic [tprc_pkg::LINE_W-1:0]        dup_q, dup_d;
  logic                               failed_q, failed_d;
  logic [tprc_pkg::EPOCH_W-1:0]       epoch_q, epoch_d;
  logic [tprc_pkg::ADDR_W-1:0]        clr_cnt_q, clr_cnt_d;
  logic                               pend_q, pend_d;
  logic [tprc_pkg::ELEM_W-1:0]        num_elem_q;

  logic [tprc_pkg::ELEM_W-1:0]        a_q, b_q, c_q;
  logic [tprc_pkg::LINE_W-1:0]        line_q;
  logic [tprc_pkg::GROUP_W-1:0]       group_q;
  logic                               last_q;

  logic                               out_valid_q;
  tprc_pkg::status_e                  out_status_q;
  logic [tprc_pkg::LINE_W-1:0]        out_fail_line_q, out_dup_q;
  logic [tprc_pkg::GROUP_W-1:0]       out_fail_group_q;
  logic                               out_done_q, out_ok_q;

  logic                               in_xfer, load_out, reported, failed_next;
  logic                               cfg_ok, line_ok, pair_ok;
  logic [tprc_pkg::ELEM_W-1:0]        pair_x, pair_y, pair_lo, pair_hi;
  logic [tprc_pkg::ADDR_W-1:0]        pair_addr;

  logic                               ram_we;
  logic [tprc_pkg::ADDR_W-1:0]        ram_waddr;
  logic [tprc_pkg::RAM_W-1:0]         ram_wdata, ram_rdata;
  logic [tprc_pkg::EPOCH_W-1:0]       rd_epoch;
  logic [tprc_pkg::LINE_W-1:0]        rd_line;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != tprc_pkg::S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;

  assign rd_epoch = ram_rdata[tprc_pkg::RAM_W-1 -: tprc_pkg::EPOCH_W];
  assign rd_line  = ram_rdata[tprc_pkg::LINE_W-1:0];

  assign cfg_ok  = ((num_elem_q == tprc_pkg::NUM_ELEM_SMALL) ||
                    (num_elem_q == tprc_pkg::NUM_ELEM_LARGE)) &&
                   (int'(num_elem_q) <= tprc_pkg::MAX_ELEMENTS);
  assign line_ok = (int'(line_q) < tprc_pkg::MAX_LINES);

  // shared pair unit: select, range/equality check, table address
  always_comb begin
    case (pair_q)
      tprc_pkg::PAIR_AB: begin pair_x = a_q; pair_y = b_q; end
      tprc_pkg::PAIR_AC: begin pair_x = a_q; pair_y = c_q; end
      default:           begin pair_x = b_q; pair_y = c_q; end
    endcase
    pair_ok   = (pair_x < num_elem_q) && (pair_y < num_elem_q) && (pair_x != pair_y);
    pair_lo   = (pair_x < pair_y) ? pair_x : pair_y;
    pair_hi   = (pair_x < pair_y) ? pair_y : pair_x;
    pair_addr = tprc_pkg::ADDR_W'(tprc_pkg::ADDR_W'(pair_lo) *
                                  tprc_pkg::ADDR_W'(tprc_pkg::MAX_ELEMENTS)) +
                tprc_pkg::ADDR_W'(pair_hi);
  end

  assign load_out    = (state_q == tprc_pkg::S_DONE) && (!out_valid_q || !out_stall_i);
  assign reported    = (status_q == tprc_pkg::ST_DUP) || (status_q == tprc_pkg::ST_INVALID);
  assign failed_next = failed_q || reported;

  always_comb begin
    state_d   = state_q;
    pair_d    = pair_q;
    status_d  = status_q;
    dup_d     = dup_q;
    failed_d  = failed_q;
    epoch_d   = epoch_q;
    clr_cnt_d = clr_cnt_q;
    pend_d    = pend_q;
    ram_we    = 1'b0;
    ram_waddr = pair_addr;
    ram_wdata = {epoch_q, line_q};

    unique case (state_q)
      tprc_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        if (clr_cnt_q == tprc_pkg::ADDR_W'(tprc_pkg::TABLE_DEPTH - 1)) begin
          clr_cnt_d = '0;
          epoch_d   = tprc_pkg::EPOCH_W'(1);
          pend_d    = 1'b0;
          state_d   = pend_q ? tprc_pkg::S_ADDR : tprc_pkg::S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + tprc_pkg::ADDR_W'(1);
        end
      end
      tprc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          pair_d   = tprc_pkg::PAIR_AB;
          status_d = tprc_pkg::ST_OK;
          dup_d    = '0;
          state_d  = tprc_pkg::S_ADDR;
          if (first_of_matrix_i) begin
            failed_d = 1'b0;
            if (epoch_q == '1) begin
              pend_d  = 1'b1;
              state_d = tprc_pkg::S_CLEAR;
            end else begin
              epoch_d = epoch_q + tprc_pkg::EPOCH_W'(1);
            end
          end
        end
      end
      tprc_pkg::S_ADDR: begin
        if ((pair_q == tprc_pkg::PAIR_AB) && failed_q) begin
          status_d = tprc_pkg::ST_SKIPPED;
          state_d  = tprc_pkg::S_DONE;
        end else if ((pair_q == tprc_pkg::PAIR_AB) && !(cfg_ok && line_ok)) begin
          status_d = tprc_pkg::ST_INVALID;
          state_d  = tprc_pkg::S_DONE;
        end else if (!pair_ok) begin
          status_d = tprc_pkg::ST_INVALID;
          state_d  = tprc_pkg::S_DONE;
        end else begin
          state_d = tprc_pkg::S_CMP;
        end
      end
      tprc_pkg::S_CMP: begin
        if (rd_epoch == epoch_q) begin
          status_d = tprc_pkg::ST_DUP;
          dup_d    = rd_line;
          state_d  = tprc_pkg::S_DONE;
        end else begin
          ram_we = 1'b1;
          unique case (pair_q)
            tprc_pkg::PAIR_AB: begin
              pair_d  = tprc_pkg::PAIR_AC;
              state_d = tprc_pkg::S_ADDR;
            end
            tprc_pkg::PAIR_AC: begin
              pair_d  = tprc_pkg::PAIR_BC;
              state_d = tprc_pkg::S_ADDR;
            end
            default: begin
              state_d = tprc_pkg::S_DONE;
            end
          endcase
        end
      end
      tprc_pkg::S_DONE: begin
        if (load_out) begin
          failed_d = failed_next;
          state_d  = tprc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tprc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tprc_pkg::S_CLEAR;
      pair_q     <= tprc_pkg::PAIR_AB;
      status_q   <= tprc_pkg::ST_OK;
      dup_q      <= '0;
      failed_q   <= 1'b0;
      epoch_q    <= tprc_pkg::EPOCH_W'(1);
      clr_cnt_q  <= '0;
      pend_q     <= 1'b0;
      num_elem_q <= tprc_pkg::NUM_ELEM_RESET;
    end else begin
      state_q   <= state_d;
      pair_q    <= pair_d;
      status_q  <= status_d;
      dup_q     <= dup_d;
      failed_q  <= failed_d;
      epoch_q   <= epoch_d;
      clr_cnt_q <= clr_cnt_d;
      pend_q    <= pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_elem_q <= cfg_num_elements_i;
      end
    end
  end

  // hold the item for the whole check
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_q     <= elem_a_i;
      b_q     <= elem_b_i;
      c_q     <= elem_c_i;
      line_q  <= line_index_i;
      group_q <= group_index_i;
      last_q  <= last_of_matrix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q     <= status_q;
      out_fail_line_q  <= reported ? line_q : '0;
      out_fail_group_q <= reported ? group_q : '0;
      out_dup_q        <= (status_q == tprc_pkg::ST_DUP) ? dup_q : '0;
      out_done_q       <= last_q;
      out_ok_q         <= last_q && !failed_next;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign fail_line_o   = out_fail_line_q;
  assign fail_group_o  = out_fail_group_q;
  assign dup_line_o    = out_dup_q;
  assign matrix_done_o = out_done_q;
  assign matrix_ok_o   = out_ok_q;

  tprc_ram #(
    .Width (tprc_pkg::RAM_W),
    .Depth (tprc_pkg::TABLE_DEPTH)
  ) u_pair_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pair_addr),
    .rdata_o (ram_rdata)
  );

  a_ok_implies_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && matrix_ok_o |-> matrix_done_o && (status_o == tprc_pkg::ST_OK))
    else $error("matrix_ok without a passing final item");

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tprc_pkg::ST_OK || status_o == tprc_pkg::ST_SKIPPED)
    |-> (fail_line_o == '0) && (fail_group_o == '0) && (dup_line_o == '0))
    else $error("failure fields set on a passing or skipped result");

  a_cmp_after_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tprc_pkg::S_CMP |-> $past(state_q) == tprc_pkg::S_ADDR)
    else $error("compare without a preceding table read");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != tprc_pkg::S_CLEAR |-> epoch_q != '0)
    else $error("current epoch matches cleared entries");

endmodule

// File: sim/triple_pair_repeat_checker_tb.sv
// ----------------------------------------------------------------------------
// triple_pair_repeat_checker_tb
// Self-checking bench: random and directed triples grouped into matrices are
// sent through the stall handshake, each result is compared with a pair
// table model kept by a scoreboard, under several element counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module triple_pair_repeat_checker_tb;

  typedef struct packed {
    tprc_pkg::status_e                 status;
    logic [tprc_pkg::LINE_W-1:0]       fail_line;
    logic [tprc_pkg::GROUP_W-1:0]      fail_group;
    logic [tprc_pkg::LINE_W-1:0]       dup_line;
    logic                              matrix_done;
    logic                              matrix_ok;
  } verdict_t;

  class pair_ledger;
    logic [tprc_pkg::ELEM_W-1:0] num_elements;
    bit                          pair_seen [tprc_pkg::MAX_ELEMENTS][tprc_pkg::MAX_ELEMENTS];
    logic [tprc_pkg::LINE_W-1:0] pair_from [tprc_pkg::MAX_ELEMENTS][tprc_pkg::MAX_ELEMENTS];
    bit                          matrix_failed;
    verdict_t                    pending[$];
    int                          faults;
    int                          notes;
    int                          status_tally [4];
    int                          closed_matrices;
    int                          clean_matrices;

    function new();
      num_elements = tprc_pkg::NUM_ELEM_RESET;
      wipe();
      matrix_failed = 1'b0;
      faults = 0;
      notes = 0;
      closed_matrices = 0;
      clean_matrices = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function void wipe();
      foreach (pair_seen[i, j]) begin
        pair_seen[i][j] = 1'b0;
        pair_from[i][j] = '0;
      end
    endfunction

    function tprc_pkg::status_e probe_pair(input logic [tprc_pkg::ELEM_W-1:0] x,
                                           input logic [tprc_pkg::ELEM_W-1:0] y,
                                           input logic [tprc_pkg::LINE_W-1:0] line,
                                           output logic [tprc_pkg::LINE_W-1:0] earlier);
      earlier = '0;
      if (x >= num_elements || y >= num_elements || x == y) return tprc_pkg::ST_INVALID;
      if (pair_seen[x][y]) begin
        earlier = pair_from[x][y];
        return tprc_pkg::ST_DUP;
      end
      pair_seen[x][y] = 1'b1;
      pair_seen[y][x] = 1'b1;
      pair_from[x][y] = line;
      pair_from[y][x] = line;
      return tprc_pkg::ST_OK;
    endfunction

    function void note_triple(input logic [tprc_pkg::ELEM_W-1:0] a,
                              input logic [tprc_pkg::ELEM_W-1:0] b,
                              input logic [tprc_pkg::ELEM_W-1:0] c,
                              input logic [tprc_pkg::LINE_W-1:0] line,
                              input logic [tprc_pkg::GROUP_W-1:0] grp,
                              input bit first, input bit last);
      verdict_t                    v;
      tprc_pkg::status_e           st;
      logic [tprc_pkg::LINE_W-1:0] earlier;
      bit                          reported;
      earlier = '0;
      if (first) begin
        wipe();
        matrix_failed = 1'b0;
      end
      if (matrix_failed) begin
        st = tprc_pkg::ST_SKIPPED;
      end else if (!(num_elements == tprc_pkg::NUM_ELEM_SMALL ||
                     num_elements == tprc_pkg::NUM_ELEM_LARGE) ||
                   num_elements > tprc_pkg::MAX_ELEMENTS || line >= tprc_pkg::MAX_LINES) begin
        st = tprc_pkg::ST_INVALID;
      end else begin
        st = probe_pair(a, b, line, earlier);
        if (st == tprc_pkg::ST_OK) st = probe_pair(a, c, line, earlier);
        if (st == tprc_pkg::ST_OK) st = probe_pair(b, c, line, earlier);
      end
      reported = (st == tprc_pkg::ST_DUP || st == tprc_pkg::ST_INVALID);
      if (reported) matrix_failed = 1'b1;
      v.status      = st;
      v.fail_line   = reported ? line : '0;
      v.fail_group  = reported ? grp : '0;
      v.dup_line    = (st == tprc_pkg::ST_DUP) ? earlier : '0;
      v.matrix_done = last;
      v.matrix_ok   = last && !matrix_failed;
      pending.push_back(v);
      notes++;
    endfunction

    function void check_verdict(input verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("[%0t] result with none pending: status %0d line %0d group %0d dup %0d",
                   $realtime, got.status, got.fail_line, got.fail_group, got.dup_line);
        return;
      end
      want = pending.pop_front();
      status_tally[got.status]++;
      if (got.matrix_done) begin
        closed_matrices++;
        if (got.matrix_ok) clean_matrices++;
      end
      if (got !== want) begin
        faults++;
        if (faults <= 10) begin
          $write("[%0t] mismatch (exp/act): status %0d/%0d fail_line %0d/%0d ",
                 $realtime, want.status, got.status, want.fail_line, got.fail_line);
          $display("fail_group %0d/%0d dup_line %0d/%0d done %0b/%0b ok %0b/%0b",
                   want.fail_group, got.fail_group, want.dup_line, got.dup_line,
                   want.matrix_done, got.matrix_done, want.matrix_ok, got.matrix_ok);
        end
      end
    endfunction
  endclass

  localparam int PHASES = 8;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [tprc_pkg::ELEM_W-1:0]   cfg_num_elements_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [tprc_pkg::ELEM_W-1:0]   elem_a_i;
  logic [tprc_pkg::ELEM_W-1:0]   elem_b_i;
  logic [tprc_pkg::ELEM_W-1:0]   elem_c_i;
  logic [tprc_pkg::LINE_W-1:0]   line_index_i;
  logic [tprc_pkg::GROUP_W-1:0]  group_index_i;
  logic                          first_of_matrix_i;
  logic                          last_of_matrix_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [tprc_pkg::STATUS_W-1:0] status_o;
  logic [tprc_pkg::LINE_W-1:0]   fail_line_o;
  logic [tprc_pkg::GROUP_W-1:0]  fail_group_o;
  logic [tprc_pkg::LINE_W-1:0]   dup_line_o;
  logic                          matrix_done_o;
  logic                          matrix_ok_o;

  pair_ledger                    ledger = new();
  bit                            steady = 1'b0;
  int                            hold_left = 0;
  logic [tprc_pkg::ELEM_W-1:0]   phase_num_elements [PHASES] =
    '{5'd21, 5'd15, 5'd21, 5'd0, 5'd31, 5'd15, 5'd22, 5'd21};
  int                            phase_items [PHASES] = '{200, 150, 100, 20, 20, 60, 20, 60};

  triple_pair_repeat_checker u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_num_elements_i (cfg_num_elements_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .elem_a_i           (elem_a_i),
    .elem_b_i           (elem_b_i),
    .elem_c_i           (elem_c_i),
    .line_index_i       (line_index_i),
    .group_index_i      (group_index_i),
    .first_of_matrix_i  (first_of_matrix_i),
    .last_of_matrix_i   (last_of_matrix_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .fail_line_o        (fail_line_o),
    .fail_group_o       (fail_group_o),
    .dup_line_o         (dup_line_o),
    .matrix_done_o      (matrix_done_o),
    .matrix_ok_o        (matrix_ok_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_triple(input logic [tprc_pkg::ELEM_W-1:0] a,
                             input logic [tprc_pkg::ELEM_W-1:0] b,
                             input logic [tprc_pkg::ELEM_W-1:0] c,
                             input logic [tprc_pkg::LINE_W-1:0] line,
                             input logic [tprc_pkg::GROUP_W-1:0] grp,
                             input bit first, input bit last);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    elem_a_i          <= a;
    elem_b_i          <= b;
    elem_c_i          <= c;
    line_index_i      <= line;
    group_index_i     <= grp;
    first_of_matrix_i <= first;
    last_of_matrix_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.note_triple(a, b, c, line, grp, first, last);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_num_elements(input logic [tprc_pkg::ELEM_W-1:0] value);
    cfg_valid_i        <= 1'b1;
    cfg_num_elements_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ledger.num_elements = value;
  endtask

  // Matrices built line by line from fresh pairs, with noise mixed in.
  task automatic play_phase(input int count);
    bit                           pair_used [32][32];
    bit                           in_line [32];
    logic [tprc_pkg::ELEM_W-1:0]  a, b, c, prev_a, prev_b;
    int                           sent, v, groups, lines, len, k, tries, roll, pick, e;
    bit                           noisy, first, last, found;
    logic [tprc_pkg::LINE_W-1:0]  line;
    logic [tprc_pkg::GROUP_W-1:0] grp;
    sent   = 0;
    prev_a = '0;
    prev_b = '0;
    v      = (ledger.num_elements == tprc_pkg::NUM_ELEM_SMALL) ? 15 : 21;
    groups = v / 3;
    lines  = (v == 15) ? 7 : 10;
    while (sent < count) begin
      roll  = $urandom_range(99);
      noisy = (roll >= 90);
      if (noisy) len = $urandom_range(1, 4);
      else if (roll < 75) len = $urandom_range(1, 2 * groups);
      else len = $urandom_range(2 * groups, lines * groups);
      if (len > count - sent) len = count - sent;
      foreach (pair_used[i, j]) pair_used[i][j] = 1'b0;
      for (k = 0; k < len; k++) begin
        line = tprc_pkg::LINE_W'(k / groups);
        grp  = tprc_pkg::GROUP_W'(k % groups);
        if (k % groups == 0)
          for (e = 0; e < 32; e++) in_line[e] = 1'b0;
        first = (k == 0) ? ($urandom_range(99) < 92) : ($urandom_range(99) < 2);
        last  = (k == len - 1) ? ($urandom_range(99) < 90) : ($urandom_range(99) < 2);
        pick  = $urandom_range(99);
        if (noisy || pick < 3) begin
          a    = tprc_pkg::ELEM_W'($urandom_range(31));
          b    = tprc_pkg::ELEM_W'($urandom_range(31));
          c    = tprc_pkg::ELEM_W'($urandom_range(31));
          line = tprc_pkg::LINE_W'($urandom_range(15));
          grp  = tprc_pkg::GROUP_W'($urandom_range(7));
        end else if (pick < 6) begin
          a = tprc_pkg::ELEM_W'($urandom_range(v - 1));
          b = tprc_pkg::ELEM_W'($urandom_range(v - 1));
          c = tprc_pkg::ELEM_W'($urandom_range(v - 1));
          case ($urandom_range(2))
            0: a = tprc_pkg::ELEM_W'($urandom_range(31, v));
            1: b = tprc_pkg::ELEM_W'($urandom_range(31, v));
            default: c = tprc_pkg::ELEM_W'($urandom_range(31, v));
          endcase
        end else if (pick < 9) begin
          a = tprc_pkg::ELEM_W'($urandom_range(v - 1));
          b = tprc_pkg::ELEM_W'($urandom_range(v - 1));
          c = (pick == 6) ? a : b;
        end else if (pick < 12 && k > 0) begin
          // reuse the last pair in swapped order
          a = prev_b;
          b = prev_a;
          c = tprc_pkg::ELEM_W'($urandom_range(v - 1));
        end else begin
          found = 1'b0;
          for (tries = 0; tries < 200 && !found; tries++) begin
            a = tprc_pkg::ELEM_W'($urandom_range(v - 1));
            b = tprc_pkg::ELEM_W'($urandom_range(v - 1));
            c = tprc_pkg::ELEM_W'($urandom_range(v - 1));
            found = a != b && a != c && b != c && !in_line[a] && !in_line[b] &&
                    !in_line[c] && !pair_used[a][b] && !pair_used[a][c] &&
                    !pair_used[b][c];
          end
          if (found) begin
            in_line[a] = 1'b1;
            in_line[b] = 1'b1;
            in_line[c] = 1'b1;
            pair_used[a][b] = 1'b1;
            pair_used[b][a] = 1'b1;
            pair_used[a][c] = 1'b1;
            pair_used[c][a] = 1'b1;
            pair_used[b][c] = 1'b1;
            pair_used[c][b] = 1'b1;
          end
        end
        send_triple(a, b, c, line, grp, first, last);
        prev_a = a;
        prev_b = b;
        sent++;
      end
    end
  endtask

  // Drain side: check every transfer, stall at random or during a long hold.
  initial begin
    verdict_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.status      = tprc_pkg::status_e'(status_o);
        got.fail_line   = fail_line_o;
        got.fail_group  = fail_group_o;
        got.dup_line    = dup_line_o;
        got.matrix_done = matrix_done_o;
        got.matrix_ok   = matrix_ok_o;
        ledger.check_verdict(got);
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < 30);
      end
    end
  end

  initial begin
    int p;
    rst_ni             <= 1'b0;
    cfg_valid_i        <= 1'b0;
    cfg_num_elements_i <= '0;
    in_valid_i         <= 1'b0;
    elem_a_i           <= '0;
    elem_b_i           <= '0;
    elem_c_i           <= '0;
    line_index_i       <= '0;
    group_index_i      <= '0;
    first_of_matrix_i  <= 1'b0;
    last_of_matrix_i   <= 1'b0;
    out_stall_i        <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_triple(5'd0,  5'd1,  5'd2,  4'd0,  3'd0, 1'b1, 1'b0);
    send_triple(5'd20, 5'd19, 5'd18, 4'd0,  3'd1, 1'b0, 1'b0);
    send_triple(5'd3,  5'd4,  5'd5,  4'd15, 3'd7, 1'b0, 1'b1);
    // no first mark: table carries over the last mark
    send_triple(5'd2,  5'd1,  5'd9,  4'd1,  3'd0, 1'b0, 1'b0);
    send_triple(5'd6,  5'd7,  5'd8,  4'd1,  3'd1, 1'b0, 1'b0);
    send_triple(5'd9,  5'd10, 5'd11, 4'd1,  3'd2, 1'b0, 1'b1);
    send_triple(5'd0,  5'd1,  5'd21, 4'd2,  3'd3, 1'b1, 1'b0);
    send_triple(5'd31, 5'd0,  5'd1,  4'd3,  3'd4, 1'b1, 1'b0);
    send_triple(5'd5,  5'd5,  5'd6,  4'd3,  3'd6, 1'b1, 1'b0);
    send_triple(5'd7,  5'd8,  5'd7,  4'd4,  3'd2, 1'b1, 1'b1);
    send_triple(5'd10, 5'd11, 5'd12, 4'd5,  3'd5, 1'b1, 1'b0);
    send_triple(5'd12, 5'd13, 5'd14, 4'd5,  3'd6, 1'b0, 1'b0);
    send_triple(5'd15, 5'd12, 5'd10, 4'd6,  3'd0, 1'b0, 1'b1);
    send_triple(5'd0,  5'd1,  5'd2,  4'd8,  3'd0, 1'b1, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_num_elements(phase_num_elements[p]);
      end
      steady = (p == 2);
      if (p == 1) hold_left = 160;
      play_phase(phase_items[p]);
    end
    drain();
    repeat (30) @(posedge clk_i);

    $display("Sent %0d triples in matrices under element counts 21 and 15 and the",
             ledger.notes);
    $display("out-of-spec counts 0, 31, 22: %0d ok, %0d dup, %0d invalid, %0d skipped,",
             ledger.status_tally[tprc_pkg::ST_OK], ledger.status_tally[tprc_pkg::ST_DUP],
             ledger.status_tally[tprc_pkg::ST_INVALID],
             ledger.status_tally[tprc_pkg::ST_SKIPPED]);
    $display("%0d/%0d clean matrices.", ledger.clean_matrices, ledger.closed_matrices);
    if (ledger.faults == 0 && ledger.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Timeout with %0d results outstanding", ledger.pending.size());
    $display("Verification failed");
    $finish;
  end

endmodule
